### hw/rtl/hmm_forward_pass_with_cutoff_macros.svh
// Assertion macros shared by the forward pass RTL.
// Needs a clock named clock and a reset named reset in the module that uses it.
`ifndef HMM_FORWARD_PASS_WITH_CUTOFF_MACROS_SVH
`define HMM_FORWARD_PASS_WITH_CUTOFF_MACROS_SVH

// Same-cycle implication.
`define HFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/hfp_pkg.sv
// Shared constants, types and arithmetic helpers of the forward pass block.
// No dependencies.
package hfp_pkg;
   localparam int MAX_STATES = 64;
   localparam int MAX_STEPS  = 64;
   localparam int ST_W       = $clog2(MAX_STATES);
   localparam int STEP_W     = $clog2(MAX_STEPS);
   localparam int TR_AW      = 2 * ST_W;
   localparam int EM_AW      = ST_W + STEP_W;
   localparam int FW_AW      = STEP_W + ST_W;

   localparam logic [31:0] Q_ONE = 32'h4000_0000;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   localparam logic [2:0] OP_LOAD_TRANS = 3'd0;
   localparam logic [2:0] OP_LOAD_EMIT  = 3'd1;
   localparam logic [2:0] OP_LOAD_CUT   = 3'd2;
   localparam logic [2:0] OP_RUN        = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   typedef struct packed {
      logic              tr_we;
      logic              em_we;
      logic              cut_we;
      logic              fw_we;
      logic [TR_AW-1:0]  tr_addr;
      logic [EM_AW-1:0]  em_addr;
      logic [STEP_W-1:0] cut_addr;
      logic [FW_AW-1:0]  fw_addr;
      logic [31:0]       wdata;
   } mem_req_type;

   typedef struct packed {
      logic [31:0] tr;
      logic [31:0] em;
      logic [31:0] cut;
      logic [31:0] fw;
   } mem_rsp_type;

   function automatic logic [31:0] q_sat(input logic [63:0] p);
      return (p[63:62] != 2'b00) ? SAT32 : p[61:30];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? SAT32 : s[31:0];
   endfunction
endpackage

### hw/rtl/hfp_store.sv
// Transition, emission, cutoff and forward memories, one port each.
// Depends on hfp_pkg for the request and response structs.
module hfp_store
   import hfp_pkg::*;
(
   input  logic        clock,
   input  mem_req_type req,
   output mem_rsp_type rsp
);
   logic [31:0] tr_mem  [MAX_STATES*MAX_STATES];
   logic [31:0] em_mem  [MAX_STATES*MAX_STEPS];
   logic [31:0] cut_mem [MAX_STEPS];
   logic [31:0] fw_mem  [MAX_STEPS*MAX_STATES];

   always_ff @(posedge clock) begin
      if (req.tr_we) tr_mem[req.tr_addr] <= req.wdata;
      if (req.em_we) em_mem[req.em_addr] <= req.wdata;
      if (req.cut_we) cut_mem[req.cut_addr] <= req.wdata;
      if (req.fw_we) fw_mem[req.fw_addr] <= req.wdata;
      rsp.tr  <= tr_mem[req.tr_addr];
      rsp.em  <= em_mem[req.em_addr];
      rsp.cut <= cut_mem[req.cut_addr];
      rsp.fw  <= fw_mem[req.fw_addr];
   end
endmodule

### hw/rtl/hfp_divider.sv
// Restoring divider for (x << 30) / d, one quotient bit per cycle, saturating.
// Depends on hfp_pkg for the saturation constant.
module hfp_divider
   import hfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [61:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic        ovf_ff, ovf_in;
   logic [32:0] trial;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      ovf_in    = ovf_ff;
      trial     = {rem_ff, num_ff[61]};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = 6'd61;
         num_in    = {dividend, 30'b0};
         rem_in    = '0;
         q_in      = '0;
         ovf_in    = 1'b0;
      end else if (active_ff) begin
         ovf_in = ovf_ff | q_ff[31];
         num_in = {num_ff[60:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 32'(trial - {1'b0, divisor});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? SAT32 : q_ff;
endmodule

### hw/rtl/hmm_forward_pass_with_cutoff.sv
// Top level of the scaled forward pass: command decode, run sequencer and result words.
// Depends on hfp_pkg, hfp_store, hfp_divider and the assertion macro header.
//
// Loads of transition, emission and cutoff entries are taken while idle, back to back.
// An alpha read returns one word. A run goes step by step, normalizing the row through the
// divider when it must be; its pace is set by the single-port memories visited once per
// product and by the one-bit-per-cycle divider.
// Each step's scale word appears on rsp_strobe for one cycle, and the receiver cannot
// stall, so it must take every word as it comes.
`include "hmm_forward_pass_with_cutoff_macros.svh"
module hmm_forward_pass_with_cutoff
   import hfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [31:0] req_value,
   input  logic [6:0]  req_num_steps,
   input  logic [6:0]  req_num_states,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_step,
   output logic [31:0] rsp_scale,
   output logic [31:0] rsp_alpha_value,
   output logic        rsp_last
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_STEP   = 4'd1;
   localparam logic [3:0] S_CUTW   = 4'd2;
   localparam logic [3:0] S_TRD    = 4'd3;
   localparam logic [3:0] S_MUL1   = 4'd4;
   localparam logic [3:0] S_MUL2   = 4'd5;
   localparam logic [3:0] S_WRITE  = 4'd6;
   localparam logic [3:0] S_SCALE  = 4'd7;
   localparam logic [3:0] S_NRD    = 4'd8;
   localparam logic [3:0] S_NSTART = 4'd9;
   localparam logic [3:0] S_NDIV   = 4'd10;
   localparam logic [3:0] S_EMIT   = 4'd11;
   localparam logic [3:0] S_RDW    = 4'd12;

   localparam logic [6:0] T_MIN = 7'd2;
   localparam logic [6:0] T_MAX = 7'(MAX_STEPS);
   localparam logic [6:0] K_MAX = 7'(MAX_STATES);

   logic [3:0]           state_ff, state_in;
   logic [STEP_W-1:0]    t_ff, t_in;
   logic [ST_W-1:0]      prev_ff, prev_in;
   logic [ST_W-1:0]      next_ff, next_in;
   logic [6:0]           nt_ff, nt_in;
   logic [6:0]           nk_ff, nk_in;
   logic [31:0]          cut_ff, cut_in;
   logic [31:0]          m1_ff, m1_in;
   logic [31:0]          em_ff, em_in;
   logic                 ok_ff, ok_in;
   logic [31:0]          acc_ff, acc_in;
   logic [31:0]          scale_ff, scale_in;
   logic [MAX_STEPS-1:0] rv_ff, rv_in;
   logic [STEP_W-1:0]    rdr_ff, rdr_in;
   logic [ST_W-1:0]      rdc_ff, rdc_in;
   logic                 strobe_ff, strobe_in;
   logic [5:0]           step_ff, step_in;
   logic [31:0]          oscale_ff, oscale_in;
   logic [31:0]          oalpha_ff, oalpha_in;
   logic                 olast_ff, olast_in;

   mem_req_type mreq;
   mem_rsp_type mrsp;
   logic        div_start;
   logic        div_done;
   logic [31:0] div_q;
   logic        accept;
   logic [ST_W-1:0]   k_last;
   logic [STEP_W-1:0] t_last;
   logic [31:0] alpha;
   logic [31:0] scale_fix;
   logic [31:0] rd_val;

   hfp_store u_store (
      .clock (clock),
      .req   (mreq),
      .rsp   (mrsp)
   );

   hfp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mrsp.fw),
      .divisor  (scale_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign k_last = ST_W'(nk_ff - 7'd1);
   assign t_last = STEP_W'(nt_ff - 7'd1);

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      prev_in   = prev_ff;
      next_in   = next_ff;
      nt_in     = nt_ff;
      nk_in     = nk_ff;
      cut_in    = cut_ff;
      m1_in     = m1_ff;
      em_in     = em_ff;
      ok_in     = ok_ff;
      acc_in    = acc_ff;
      scale_in  = scale_ff;
      rv_in     = rv_ff;
      rdr_in    = rdr_ff;
      rdc_in    = rdc_ff;
      strobe_in = 1'b0;
      step_in   = step_ff;
      oscale_in = oscale_ff;
      oalpha_in = oalpha_ff;
      olast_in  = olast_ff;
      div_start = 1'b0;
      mreq          = '0;
      mreq.tr_addr  = {prev_ff, next_ff};
      mreq.em_addr  = {next_ff, t_ff};
      mreq.cut_addr = t_ff;
      mreq.fw_addr  = {t_ff, next_ff};
      mreq.wdata    = acc_ff;
      alpha     = (prev_ff == '0) ? Q_ONE : '0;
      if (t_ff != STEP_W'(1)) alpha = mrsp.fw;
      scale_fix = (scale_ff == '0) ? Q_ONE : scale_ff;
      rd_val    = (rdr_ff == '0) ? ((rdc_ff == '0) ? Q_ONE : '0) : mrsp.fw;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mreq.wdata = req_value;
               case (req_operation)
                  OP_LOAD_TRANS: begin
                     mreq.tr_we   = 1'b1;
                     mreq.tr_addr = {req_row_index, req_col_index};
                  end
                  OP_LOAD_EMIT: begin
                     mreq.em_we   = 1'b1;
                     mreq.em_addr = {req_row_index, req_col_index};
                  end
                  OP_LOAD_CUT: begin
                     mreq.cut_we   = 1'b1;
                     mreq.cut_addr = req_row_index;
                  end
                  OP_RUN: begin
                     nt_in = (req_num_steps < T_MIN) ? T_MIN :
                             (req_num_steps > T_MAX) ? T_MAX : req_num_steps;
                     nk_in = (req_num_states == '0) ? 7'd1 :
                             (req_num_states > K_MAX) ? K_MAX : req_num_states;
                     rv_in    = MAX_STEPS'(1);
                     t_in     = STEP_W'(1);
                     state_in = S_STEP;
                  end
                  OP_READ: begin
                     mreq.fw_addr = {req_row_index, req_col_index};
                     rdr_in   = req_row_index;
                     rdc_in   = req_col_index;
                     state_in = S_RDW;
                  end
                  default: ;
               endcase
            end
         end
         S_STEP: begin
            next_in  = '0;
            prev_in  = '0;
            acc_in   = '0;
            scale_in = '0;
            state_in = S_CUTW;
         end
         S_CUTW: begin
            cut_in   = mrsp.cut;
            state_in = S_TRD;
         end
         S_TRD: begin
            mreq.fw_addr = {STEP_W'(t_ff - STEP_W'(1)), prev_ff};
            state_in     = S_MUL1;
         end
         S_MUL1: begin
            m1_in    = q_sat({32'b0, alpha} * {32'b0, mrsp.tr});
            em_in    = mrsp.em;
            ok_in    = (mrsp.tr > cut_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (ok_ff) acc_in = sat_add(acc_ff, q_sat({32'b0, m1_ff} * {32'b0, em_ff}));
            if (prev_ff == k_last) begin
               state_in = S_WRITE;
            end else begin
               prev_in  = prev_ff + ST_W'(1);
               state_in = S_TRD;
            end
         end
         S_WRITE: begin
            mreq.fw_we = 1'b1;
            scale_in   = sat_add(scale_ff, acc_ff);
            acc_in     = '0;
            prev_in    = '0;
            if (next_ff == k_last) begin
               state_in = S_SCALE;
            end else begin
               next_in  = next_ff + ST_W'(1);
               state_in = S_TRD;
            end
         end
         S_SCALE: begin
            scale_in  = scale_fix;
            rv_in[t_ff] = 1'b1;
            next_in   = '0;
            state_in  = (scale_fix == Q_ONE) ? S_EMIT : S_NRD;
         end
         S_NRD: begin
            state_in = S_NSTART;
         end
         S_NSTART: begin
            div_start = 1'b1;
            state_in  = S_NDIV;
         end
         S_NDIV: begin
            if (div_done) begin
               mreq.fw_we = 1'b1;
               mreq.wdata = div_q;
               if (next_ff == k_last) begin
                  state_in = S_EMIT;
               end else begin
                  next_in  = next_ff + ST_W'(1);
                  state_in = S_NRD;
               end
            end
         end
         S_EMIT: begin
            strobe_in = 1'b1;
            step_in   = t_ff;
            oscale_in = scale_ff;
            oalpha_in = '0;
            olast_in  = (t_ff == t_last);
            if (t_ff == t_last) begin
               state_in = S_IDLE;
            end else begin
               t_in     = t_ff + STEP_W'(1);
               state_in = S_STEP;
            end
         end
         S_RDW: begin
            strobe_in = 1'b1;
            step_in   = rdr_ff;
            oscale_in = '0;
            oalpha_in = (rv_ff[rdr_ff] && ({1'b0, rdc_ff} < nk_ff)) ? rd_val : '0;
            olast_in  = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rv_ff     <= '0;
         nk_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         nk_ff     <= nk_in;
         strobe_ff <= strobe_in;
      end
      t_ff      <= t_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      nt_ff     <= nt_in;
      cut_ff    <= cut_in;
      m1_ff     <= m1_in;
      em_ff     <= em_in;
      ok_ff     <= ok_in;
      acc_ff    <= acc_in;
      scale_ff  <= scale_in;
      rdr_ff    <= rdr_in;
      rdc_ff    <= rdc_in;
      step_ff   <= step_in;
      oscale_ff <= oscale_in;
      oalpha_ff <= oalpha_in;
      olast_ff  <= olast_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_step        = step_ff;
   assign rsp_scale       = oscale_ff;
   assign rsp_alpha_value = oalpha_ff;
   assign rsp_last        = olast_ff;

   `HFP_ASSERT_NEXT(a_word_after_busy, !busy, !rsp_strobe, "result word without work")
   `HFP_ASSERT_NOW(a_div_in_wait, div_done, state_ff == S_NDIV, "divider result lost")
   `HFP_ASSERT_NEXT(a_run_starts, accept && req_operation == OP_RUN, state_ff == S_STEP,
      "run not started")
   `HFP_ASSERT_NOW(a_scale_nonzero, rsp_strobe && !rsp_last, rsp_scale != '0,
      "zero scale reported")
endmodule
